### rtl/cumulative_ack_window_tracker_core_assert.svh
// Assertion macros for the cumulative ACK window tracker.
// Depends on clk and rst_n being visible in the including module.
`ifndef CUMULATIVE_ACK_WINDOW_TRACKER_CORE_ASSERT_SVH
`define CUMULATIVE_ACK_WINDOW_TRACKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define CAWT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define CAWT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CAWT_ASSERT(label, prop, msg)
`define CAWT_NEVER(label, cond, msg)

`endif

`endif

### rtl/cawt_pkg.sv
// Shared types and constants for the cumulative ACK window tracker.
// No dependencies.
package cawt_pkg;

    // Frame number width and receive window (window is a power of two)
    localparam int unsigned FRAME_W    = 32;
    localparam int unsigned ACK_WINDOW = 256;
    localparam int unsigned SLOT_W     = $clog2(ACK_WINDOW);

    // Shared unit operations
    typedef enum logic
    {
        ALU_SUB,
        ALU_INC
    } alu_op_t;

    // Shared unit flags
    typedef struct packed
    {
        logic not_above;   // SUB: a <= b
        logic beyond;      // SUB: a - b > ACK_WINDOW
        logic at_top;      // INC: a was all ones
    } alu_status_t;

    // Mark map write command
    typedef struct packed
    {
        logic              en;
        logic              val;
        logic [SLOT_W-1:0] idx;
    } mark_wr_t;

endpackage

### rtl/cumulative_ack_window_tracker_core.sv
// Cumulative ACK window tracker: frame number in, cumulative ACK out.
// Failed, stale, duplicate or out-of-window number: flagged at the check, then output.
// New in-window number: its mark is set, then the base steps over each following mark,
// a mark fetch and an adder step each. One word at a time; stalls delay the result.
// Reset (async, active low): base 0, no result pending; the marks are cleared
// one per cycle after reset, ready held low until that clearing pass ends.
module cumulative_ack_window_tracker_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cawt_pkg::FRAME_W-1:0]   frame_number,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cawt_pkg::FRAME_W-1:0]   highest_contiguous,
    output logic                           stale_or_duplicate,
    output logic                           beyond_window
);

`include "cumulative_ack_window_tracker_core_assert.svh"

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_ADVANCE,
        ST_FINISH
    } state_t;

    state_t                         state_reg, state_next;
    logic [cawt_pkg::FRAME_W-1:0]   base_reg, base_next;
    logic [cawt_pkg::FRAME_W-1:0]   frame_reg, frame_next;
    logic                           stale_reg, stale_next;
    logic                           beyond_reg, beyond_next;
    logic                           out_valid_reg, out_valid_next;
    logic [cawt_pkg::FRAME_W-1:0]   out_ack_reg, out_ack_next;
    logic                           out_stale_reg, out_stale_next;
    logic                           out_beyond_reg, out_beyond_next;
    logic                           out_free;

    cawt_pkg::alu_op_t              alu_op;
    logic [cawt_pkg::FRAME_W-1:0]   alu_a;
    logic [cawt_pkg::FRAME_W-1:0]   alu_sum;
    cawt_pkg::alu_status_t          alu_status;
    logic [cawt_pkg::SLOT_W-1:0]    mark_rd_idx;
    logic                           mark_rd;
    logic                           mark_busy;
    cawt_pkg::mark_wr_t             mark_wr;

    // Shared unit operand select: distance check, then base+1 steps
    always_comb
    begin
        if (state_reg == ST_CHECK)
        begin
            alu_op = cawt_pkg::ALU_SUB;
            alu_a  = frame_reg;
        end
        else
        begin
            alu_op = cawt_pkg::ALU_INC;
            alu_a  = base_reg;
        end
    end

    // Mark fetch: incoming frame slot while idle, base+1 slot otherwise
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            mark_rd_idx = frame_number[cawt_pkg::SLOT_W-1:0];
        end
        else
        begin
            mark_rd_idx = alu_sum[cawt_pkg::SLOT_W-1:0];
        end
    end

    cawt_alu u_alu
    (
        .op     (alu_op),
        .a      (alu_a),
        .b      (base_reg),
        .sum    (alu_sum),
        .status (alu_status)
    );

    cawt_marks u_marks
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (mark_rd_idx),
        .rd_mark (mark_rd),
        .wr      (mark_wr),
        .busy    (mark_busy)
    );

    assign out_free = !out_valid_reg || out_ready;

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        frame_next      = frame_reg;
        stale_next      = stale_reg;
        beyond_next     = beyond_reg;
        out_valid_next  = out_valid_reg;
        out_ack_next    = out_ack_reg;
        out_stale_next  = out_stale_reg;
        out_beyond_next = out_beyond_reg;
        mark_wr         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    frame_next = frame_number;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                stale_next  = 1'b0;
                beyond_next = 1'b0;
                if (alu_status.not_above)
                begin
                    stale_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (alu_status.beyond)
                begin
                    beyond_next = 1'b1;
                    state_next  = ST_FINISH;
                end
                else if (mark_rd)
                begin
                    stale_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    mark_wr.en  = 1'b1;
                    mark_wr.val = 1'b1;
                    mark_wr.idx = frame_reg[cawt_pkg::SLOT_W-1:0];
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // base+1 slot read issued this cycle
                state_next = ST_ADVANCE;
            end
            ST_ADVANCE:
            begin
                // Step over one mark; stop at a gap or at all ones
                if (alu_status.at_top || !mark_rd)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    mark_wr.en  = 1'b1;
                    mark_wr.val = 1'b0;
                    mark_wr.idx = alu_sum[cawt_pkg::SLOT_W-1:0];
                    base_next   = alu_sum;
                    state_next  = ST_FETCH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_ack_next    = base_reg;
                    out_stale_next  = stale_reg;
                    out_beyond_next = beyond_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_reg       <= '0;
            frame_reg      <= '0;
            stale_reg      <= 1'b0;
            beyond_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_ack_reg    <= '0;
            out_stale_reg  <= 1'b0;
            out_beyond_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            frame_reg      <= frame_next;
            stale_reg      <= stale_next;
            beyond_reg     <= beyond_next;
            out_valid_reg  <= out_valid_next;
            out_ack_reg    <= out_ack_next;
            out_stale_reg  <= out_stale_next;
            out_beyond_reg <= out_beyond_next;
        end
    end

    assign in_ready           = (state_reg == ST_IDLE) && !mark_busy;
    assign out_valid          = out_valid_reg;
    assign highest_contiguous = out_ack_reg;
    assign stale_or_duplicate = out_stale_reg;
    assign beyond_window      = out_beyond_reg;

    // Base never drops and moves up by at most one per cycle
    `CAWT_ASSERT(a_step, base_reg - $past(base_reg) <= 32'd1, "base jump")
    // Base changes only while advancing
    `CAWT_ASSERT(a_hold, state_reg != ST_ADVANCE |=> base_reg == $past(base_reg), "base moved")
    // Both flags never set on one word
    `CAWT_NEVER(a_flags, out_stale_reg && out_beyond_reg, "both flags set")
    // A finishing item with a free output slot lands in the output register
    `CAWT_ASSERT(a_finish, state_reg == ST_FINISH && out_free |=> out_valid_reg, "word lost")

endmodule

### rtl/cawt_alu.sv
// Shared adder/comparator: frame-minus-base distance check and base increment.
// Depends on cawt_pkg.
module cawt_alu
(
    input  cawt_pkg::alu_op_t                  op,
    input  logic [cawt_pkg::FRAME_W-1:0]      a,
    input  logic [cawt_pkg::FRAME_W-1:0]      b,
    output logic [cawt_pkg::FRAME_W-1:0]      sum,
    output cawt_pkg::alu_status_t              status
);

    logic [cawt_pkg::FRAME_W:0] opnd_b;
    logic [cawt_pkg::FRAME_W:0] res;

    // One 33-bit adder: a + ~b + 1 for SUB, a + 0 + 1 for INC
    always_comb
    begin
        if (op == cawt_pkg::ALU_SUB)
        begin
            opnd_b = ~{1'b0, b};
        end
        else
        begin
            opnd_b = '0;
        end
        res = {1'b0, a} + opnd_b + {{cawt_pkg::FRAME_W{1'b0}}, 1'b1};
    end

    assign sum = res[cawt_pkg::FRAME_W-1:0];

    // Flags; bit 32 is borrow for SUB, carry for INC
    always_comb
    begin
        status.not_above = res[cawt_pkg::FRAME_W] || (sum == '0);
        status.beyond    = !res[cawt_pkg::FRAME_W]
                         && (sum > cawt_pkg::FRAME_W'(cawt_pkg::ACK_WINDOW));
        status.at_top    = res[cawt_pkg::FRAME_W];
    end

endmodule

### rtl/cawt_marks.sv
// Arrival mark map: one bit per window slot, cleared by a pass after reset.
// Depends on cawt_pkg.
module cawt_marks
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [cawt_pkg::SLOT_W-1:0]     rd_idx,
    output logic                            rd_mark,
    input  cawt_pkg::mark_wr_t              wr,
    output logic                            busy
);

    logic                           mark_mem [cawt_pkg::ACK_WINDOW];
    logic                           rd_mark_reg;
    logic [cawt_pkg::SLOT_W-1:0]    clr_idx_reg, clr_idx_next;
    logic                           busy_reg, busy_next;
    logic                           wr_en;
    logic                           wr_val;
    logic [cawt_pkg::SLOT_W-1:0]    wr_idx;

    // Clearing pass: one slot per cycle after reset
    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == '1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_idx_reg <= clr_idx_next;
            busy_reg    <= busy_next;
        end
    end

    // Write port: clearing pass, then set on arrival / clear as the base passes
    always_comb
    begin
        if (busy_reg)
        begin
            wr_en  = 1'b1;
            wr_val = 1'b0;
            wr_idx = clr_idx_reg;
        end
        else
        begin
            wr_en  = wr.en;
            wr_val = wr.val;
            wr_idx = wr.idx;
        end
    end

    // One write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mark_mem[wr_idx] <= wr_val;
        end
        rd_mark_reg <= mark_mem[rd_idx];
    end

    assign rd_mark = rd_mark_reg;
    assign busy    = busy_reg;

endmodule
